FILE: rtl/lgpbi_pkg.sv
`default_nettype none
package lgpbi_pkg;

  localparam int unsigned CmdW  = 2;
  localparam int unsigned OpW   = 2;
  localparam int unsigned ByteW = 8;
  localparam int unsigned DestW = 3;
  localparam int unsigned LaneW = 6;
  localparam int unsigned TidxW = 16;
  localparam int unsigned TabDepth = 1 << TidxW;

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD_TAB = 2'd0,
    CMD_WR_LANE  = 2'd1,
    CMD_EXEC     = 2'd2,
    CMD_RD_LANE  = 2'd3
  } cmd_e;

  typedef enum logic [OpW-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef struct packed {
    logic             last_instruction;
    logic [TidxW-1:0] table_index;
    logic [ByteW-1:0] data_value;
    logic [LaneW-1:0] lane;
    logic [ByteW-1:0] argument_code;
    op_e              operation;
    logic [ByteW-1:0] source_code;
    logic [DestW-1:0] dest_register;
    cmd_e             command;
  } item_t;

  typedef struct packed {
    logic             program_done;
    logic             bad_code;
    logic [ByteW-1:0] read_value;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/lgpbi_regfile.sv
`default_nettype none
module lgpbi_regfile #(
  parameter int unsigned Depth = 512,
  parameter int unsigned AddrW = 9
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [AddrW-1:0]         waddr_i,
  input  wire logic [lgpbi_pkg::ByteW-1:0] wdata_i,
  input  wire logic [AddrW-1:0]         raddr_a_i,
  input  wire logic [AddrW-1:0]         raddr_b_i,
  output logic [lgpbi_pkg::ByteW-1:0]   rdata_a_o,
  output logic [lgpbi_pkg::ByteW-1:0]   rdata_b_o
);
  import lgpbi_pkg::*;

  logic [ByteW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end
endmodule
`default_nettype wire

FILE: rtl/lgpbi_divtab.sv
`default_nettype none
module lgpbi_divtab (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [lgpbi_pkg::TidxW-1:0] waddr_i,
  input  wire logic [lgpbi_pkg::ByteW-1:0] wdata_i,
  input  wire logic [lgpbi_pkg::TidxW-1:0] raddr_i,
  output logic [lgpbi_pkg::ByteW-1:0]      rdata_o
);
  import lgpbi_pkg::*;

  logic [ByteW-1:0] mem_q [TabDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

FILE: rtl/lgpbi_alu.sv
`default_nettype none
module lgpbi_alu (
  input  wire lgpbi_pkg::op_e              op_i,
  input  wire logic [lgpbi_pkg::ByteW-1:0] a_i,
  input  wire logic [lgpbi_pkg::ByteW-1:0] b_i,
  output logic [lgpbi_pkg::ByteW-1:0]      res_o
);
  import lgpbi_pkg::*;

  logic [2*ByteW-1:0] prod;

  always_comb begin
    prod = (2*ByteW)'(a_i) * (2*ByteW)'(b_i);
    unique case (op_i)
      OP_ADD:  res_o = a_i + b_i;
      OP_SUB:  res_o = a_i - b_i;
      OP_MUL:  res_o = prod[ByteW-1:0];
      default: res_o = '0; // table lookup result is chosen after the table read
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/linear_gp_byte_interpreter.sv
`default_nettype none
// Linear GP byte interpreter. Host items load the 64K-byte division table and
// register lanes, read lanes back, or execute one instruction over all
// NUM_CASES fitness cases. Every item gives exactly one result item. An execute
// item sweeps one lane per cycle through a three-stage pipeline (register file
// read, ALU and table read, write back). An instruction with a bad register
// code writes nothing. Items are taken one at a time; a finished result waits
// in the output register.
module linear_gp_byte_interpreter #(
  parameter int unsigned NUM_REGS  = 8,
  parameter int unsigned NUM_CASES = 64,
  parameter int unsigned IMM_MAX   = 127
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // command, dest_register, source_code, operation, argument_code, lane,
  // data_value, table_index (bits 52:0), zero fill
  input  wire logic [55:0] s_axis_tdata,
  input  wire logic        s_axis_tlast,   // last_instruction
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // read_value, bad_code, program_done (bits 9:0), zero fill
  output logic [15:0]      m_axis_tdata
);
  import lgpbi_pkg::*;

  localparam int unsigned Depth = NUM_REGS * NUM_CASES;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned RegW  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int unsigned LnW   = (NUM_CASES > 1) ? $clog2(NUM_CASES) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_EXEC = 3'd2;
  localparam logic [2:0] ST_RESP = 3'd3;

  logic [2:0] state_q, state_d;
  item_t      in_item;
  logic       in_acc;

  assign in_item = item_t'({s_axis_tlast, s_axis_tdata[52:0]});
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // code decode for the incoming item
  logic [8:0]  src_diff, arg_diff;
  logic        src_ok, arg_imm, arg_ok, dest_ok, lane_ok, exec_bad;
  logic [RegW-1:0] src_reg, arg_reg, dst_reg;

  always_comb begin
    src_diff = {1'b0, in_item.source_code} - 9'(IMM_MAX + 1);
    arg_diff = {1'b0, in_item.argument_code} - 9'(IMM_MAX + 1);
    src_ok   = (in_item.source_code > 8'(IMM_MAX)) && (src_diff < 9'(NUM_REGS));
    arg_imm  = (in_item.argument_code <= 8'(IMM_MAX));
    arg_ok   = arg_imm || (arg_diff < 9'(NUM_REGS));
    dest_ok  = 7'(in_item.dest_register) < 7'(NUM_REGS);
    lane_ok  = 13'(in_item.lane) < 13'(NUM_CASES);
    exec_bad = !dest_ok || !src_ok || !arg_ok;
    src_reg  = RegW'(src_diff);
    arg_reg  = RegW'(arg_diff);
    dst_reg  = RegW'(in_item.dest_register);
  end

  // execute context
  logic [RegW-1:0] sreg_q, areg_q, dreg_q;
  logic            aimm_q;
  logic [ByteW-1:0] aval_q;
  op_e             op_q;
  logic [LnW-1:0]  cnt_q;
  logic            issue_q;
  logic            v1_q, v2_q;
  logic [LnW-1:0]  lane1_q, lane2_q;
  op_e             op2_q;
  logic [ByteW-1:0] alu2_q;
  result_t         res_q;
  logic            m_valid_q;
  result_t         m_data_q;

  // memories
  logic             rf_we;
  logic [AddrW-1:0] rf_waddr, rf_ra, rf_rb;
  logic [ByteW-1:0] rf_wdata, rf_da, rf_db, opnd_b, alu_res, tab_rd;
  logic [TidxW-1:0] tab_raddr;

  always_comb begin
    rf_ra = AddrW'(sreg_q) * AddrW'(NUM_CASES) + AddrW'(cnt_q);
    rf_rb = AddrW'(areg_q) * AddrW'(NUM_CASES) + AddrW'(cnt_q);
    if (state_q == ST_IDLE) begin
      rf_ra = AddrW'(dst_reg) * AddrW'(NUM_CASES) + AddrW'(in_item.lane);
    end
    rf_we    = 1'b0;
    rf_waddr = AddrW'(dreg_q) * AddrW'(NUM_CASES) + AddrW'(lane2_q);
    rf_wdata = (op2_q == OP_DIV) ? tab_rd : alu2_q;
    if (v2_q) begin
      rf_we = 1'b1;
    end else if (in_acc && in_item.command == CMD_WR_LANE && dest_ok && lane_ok) begin
      rf_we    = 1'b1;
      rf_waddr = AddrW'(dst_reg) * AddrW'(NUM_CASES) + AddrW'(in_item.lane);
      rf_wdata = in_item.data_value;
    end
  end

  lgpbi_regfile #(.Depth(Depth), .AddrW(AddrW)) u_rf (
    .clk_i, .we_i(rf_we), .waddr_i(rf_waddr), .wdata_i(rf_wdata),
    .raddr_a_i(rf_ra), .raddr_b_i(rf_rb), .rdata_a_o(rf_da), .rdata_b_o(rf_db)
  );

  assign opnd_b    = aimm_q ? aval_q : rf_db;
  assign tab_raddr = {rf_da, opnd_b};

  lgpbi_alu u_alu (.op_i(op_q), .a_i(rf_da), .b_i(opnd_b), .res_o(alu_res));

  lgpbi_divtab u_tab (
    .clk_i,
    .we_i(in_acc && in_item.command == CMD_LOAD_TAB),
    .waddr_i(in_item.table_index), .wdata_i(in_item.data_value),
    .raddr_i(tab_raddr), .rdata_o(tab_rd)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_item.command)
            CMD_RD_LANE: state_d = (dest_ok && lane_ok) ? ST_RD : ST_RESP;
            CMD_EXEC:    state_d = exec_bad ? ST_RESP : ST_EXEC;
            default:     state_d = ST_RESP;
          endcase
        end
      end
      ST_RD:   state_d = ST_RESP;
      ST_EXEC: if (!issue_q && !v1_q && !v2_q) state_d = ST_RESP;
      ST_RESP: if (!m_valid_q || m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      issue_q   <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= issue_q;
      v2_q    <= v1_q;
      if (in_acc && in_item.command == CMD_EXEC && !exec_bad) begin
        issue_q <= 1'b1;
      end else if (issue_q && cnt_q == LnW'(NUM_CASES - 1)) begin
        issue_q <= 1'b0;
      end
      if (state_q == ST_RESP && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sreg_q <= src_reg;
      areg_q <= arg_reg;
      dreg_q <= dst_reg;
      aimm_q <= arg_imm;
      aval_q <= in_item.argument_code;
      op_q   <= in_item.operation;
      cnt_q  <= '0;
      res_q.read_value   <= '0;
      res_q.bad_code     <= (in_item.command == CMD_EXEC) ? exec_bad
                          : (in_item.command == CMD_LOAD_TAB) ? 1'b0 : !(dest_ok && lane_ok);
      res_q.program_done <= (in_item.command == CMD_EXEC) && in_item.last_instruction;
    end else if (issue_q) begin
      cnt_q <= cnt_q + 1'b1;
    end
    if (state_q == ST_RD) begin
      res_q.read_value <= rf_da;
    end
    lane1_q <= cnt_q;
    lane2_q <= lane1_q;
    op2_q   <= op_q;
    alu2_q  <= alu_res;
    if (state_q == ST_RESP && (!m_valid_q || m_axis_tready)) begin
      m_data_q <= res_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'b0, m_data_q};

  // write-back only happens inside an execute sweep
  a_wb_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> state_q == ST_EXEC) else $error("write-back outside execute");

  // a bad instruction never starts a sweep
  a_bad_no_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_item.command == CMD_EXEC && exec_bad) |=> !issue_q && state_q == ST_RESP)
    else $error("bad instruction started a sweep");

  // input is only taken with no sweep in flight
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !issue_q && !v1_q && !v2_q) else $error("item taken mid sweep");
endmodule
`default_nettype wire
